// ===== rtl/idte_pkg.sv =====
// Shared constants and types for the directory-record date to epoch converter.
// Depends on nothing; compile first.
`default_nettype none

package idte_pkg;

    localparam int PIPE_STAGES = 6;

    localparam int FIELD_W  = 8;
    localparam int YEAR_W   = 12;
    localparam int MON_W    = 8;
    localparam int PC100_W  = 25;
    localparam int PC400_W  = 23;
    localparam int MPROD_W  = 17;
    localparam int MQ_W     = 31;
    localparam int BASE_W   = 21;
    localparam int DAYS_W   = 18;
    localparam int HOURS_W  = 22;
    localparam int MINS_W   = 28;
    localparam int ZADJ_W   = 17;
    localparam int EPOCH_W  = 34;

    localparam int RECIP_SHIFT_100 = 19;
    localparam int RECIP_SHIFT_3   = 17;

    localparam logic [YEAR_W-1:0]  YEAR_BASE      = 12'd1900;
    localparam logic [MON_W-1:0]   MON_WRAP_MAX   = 8'd2;
    localparam logic [MON_W-1:0]   MON_SHIFT      = 8'd2;
    localparam logic [MON_W-1:0]   MON_WRAP_ADD   = 8'd10;
    localparam logic [12:0]        RECIP_100      = 13'd5243;
    localparam logic [15:0]        RECIP_3        = 16'd43691;
    localparam logic [8:0]         MONTH_NUM      = 9'd367;
    localparam logic [8:0]         DAYS_PER_YEAR  = 9'd365;
    localparam logic [BASE_W-1:0]  DAYS_TO_EPOCH  = 21'd719499;

    localparam logic signed [FIELD_W-1:0] ZONE_LIMIT     = 8'sd52;
    localparam logic signed [ZADJ_W-1:0]  ZONE_STEP_SECS = 17'sd900;

    typedef struct packed {
        logic                   in_ready;
        logic [PIPE_STAGES-1:0] load;
        logic [PIPE_STAGES-1:0] valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/idte_if.sv =====
// Channel interfaces: date input, epoch result and mode register write.
// Depends on idte_pkg for field widths.
`default_nettype none

interface idte_date_if;
    logic                         valid;
    logic                         ready;
    logic [idte_pkg::FIELD_W-1:0] years_since_1900;
    logic [idte_pkg::FIELD_W-1:0] month_raw;
    logic [idte_pkg::FIELD_W-1:0] day_raw;
    logic [idte_pkg::FIELD_W-1:0] hour_raw;
    logic [idte_pkg::FIELD_W-1:0] minute_raw;
    logic [idte_pkg::FIELD_W-1:0] second_raw;
    logic [idte_pkg::FIELD_W-1:0] zone_byte;

    modport source (
        output valid, years_since_1900, month_raw, day_raw, hour_raw,
               minute_raw, second_raw, zone_byte,
        input  ready
    );
    modport sink (
        input  valid, years_since_1900, month_raw, day_raw, hour_raw,
               minute_raw, second_raw, zone_byte,
        output ready
    );
endinterface

interface idte_epoch_if;
    logic                                valid;
    logic                                ready;
    logic signed [idte_pkg::EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, epoch_seconds, input ready);
    modport sink (input valid, epoch_seconds, output ready);
endinterface

interface idte_cfg_if;
    logic valid;
    logic ready;
    logic high_sierra_mode;

    modport source (output valid, high_sierra_mode, input ready);
    modport sink (input valid, high_sierra_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/iso9660_date_to_epoch.sv =====
// Top level: six-stage pipeline converting a directory-record date to epoch seconds.
// Depends on idte_pkg, the channel interfaces in idte_if and idte_pipe_ctrl.
//
//   channel | modport | payload                                  | direction
//   date    | sink    | seven date bytes, zone_byte last          | in
//   epoch   | source  | epoch_seconds, 34-bit two's complement    | out
//   cfg     | sink    | high_sierra_mode                         | in
//
// One item per cycle sustained while epoch.ready holds.
// Depth is set by the chain of constant multiplies: reciprocal divides, day count,
// then hours, minutes and seconds scaling, one step per stage.
// Reset clears the stage valid bits and the mode register; payload is not reset.
// A stalled stage holds; an empty stage ahead of it still loads.
`default_nettype none

module iso9660_date_to_epoch (
    input  wire logic      clk,
    input  wire logic      rst_n,
    idte_date_if.sink      date,
    idte_epoch_if.source   epoch,
    idte_cfg_if.sink       cfg
);
    import idte_pkg::*;

    pipe_ctl_t ctl;

    logic hs_mode_reg;

    idte_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (date.valid),
        .out_ready (epoch.ready),
        .ctl       (ctl)
    );

    assign date.ready = ctl.in_ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            hs_mode_reg <= cfg.high_sierra_mode;
        end
    end

    // stage 1: shift year/month, reciprocal products, zone adjustment
    logic                       mon_wrap;
    logic signed [FIELD_W-1:0]  zone_s;
    logic                       zone_ok;
    logic signed [ZADJ_W-1:0]   zone_ext;
    logic [YEAR_W-1:0]          s1_year_next;
    logic [MON_W-1:0]           s1_mon_next;
    logic [PC100_W-1:0]         s1_pc100_next;
    logic [PC400_W-1:0]         s1_pc400_next;
    logic [MPROD_W-1:0]         s1_mprod_next;
    logic signed [ZADJ_W-1:0]   s1_zadj_next;

    always_comb
    begin
        mon_wrap     = date.month_raw <= MON_WRAP_MAX;
        zone_s       = $signed(date.zone_byte);
        zone_ok      = !hs_mode_reg && (zone_s >= -ZONE_LIMIT) && (zone_s <= ZONE_LIMIT);
        zone_ext     = ZADJ_W'(zone_s);
        s1_year_next = YEAR_W'(date.years_since_1900) + YEAR_BASE - YEAR_W'(mon_wrap);
        s1_mon_next  = mon_wrap ? date.month_raw + MON_WRAP_ADD : date.month_raw - MON_SHIFT;
        s1_pc100_next = PC100_W'(s1_year_next) * PC100_W'(RECIP_100);
        s1_pc400_next = PC400_W'(s1_year_next[YEAR_W-1:2]) * PC400_W'(RECIP_100);
        s1_mprod_next = MPROD_W'(s1_mon_next) * MPROD_W'(MONTH_NUM);
        s1_zadj_next  = zone_ok ? zone_ext * ZONE_STEP_SECS : '0;
    end

    logic [YEAR_W-1:0]         s1_year_reg;
    logic [PC100_W-1:0]        s1_pc100_reg;
    logic [PC400_W-1:0]        s1_pc400_reg;
    logic [MPROD_W-1:0]        s1_mprod_reg;
    logic [FIELD_W-1:0]        s1_day_reg;
    logic [FIELD_W-1:0]        s1_hour_reg;
    logic [FIELD_W-1:0]        s1_min_reg;
    logic [FIELD_W-1:0]        s1_sec_reg;
    logic signed [ZADJ_W-1:0]  s1_zadj_reg;

    // stage 2: quotients by 100 and 400, month term product, year days
    logic [5:0]                q100;
    logic [3:0]                q400;
    logic [MPROD_W-3:0]        mon_q4;
    logic [MQ_W-1:0]           s2_mq_next;
    logic [BASE_W-1:0]         s2_y365_next;
    logic [BASE_W-1:0]         s2_base_next;

    always_comb
    begin
        q100   = s1_pc100_reg[PC100_W-1:RECIP_SHIFT_100];
        q400   = s1_pc400_reg[PC400_W-1:RECIP_SHIFT_100];
        mon_q4 = s1_mprod_reg[MPROD_W-1:2];
        s2_mq_next   = MQ_W'(mon_q4) * MQ_W'(RECIP_3);
        s2_y365_next = BASE_W'(s1_year_reg) * BASE_W'(DAYS_PER_YEAR);
        s2_base_next = BASE_W'(s1_year_reg[YEAR_W-1:2]) - BASE_W'(q100) + BASE_W'(q400)
                     + BASE_W'(s1_day_reg) - DAYS_TO_EPOCH;
    end

    logic [MQ_W-1:0]           s2_mq_reg;
    logic [BASE_W-1:0]         s2_y365_reg;
    logic [BASE_W-1:0]         s2_base_reg;
    logic [FIELD_W-1:0]        s2_hour_reg;
    logic [FIELD_W-1:0]        s2_min_reg;
    logic [FIELD_W-1:0]        s2_sec_reg;
    logic signed [ZADJ_W-1:0]  s2_zadj_reg;

    // stage 3: day count relative to the epoch
    logic [BASE_W-1:0]         day_sum;
    logic [DAYS_W-1:0]         s3_days_next;

    always_comb
    begin
        day_sum      = s2_base_reg + s2_y365_reg + BASE_W'(s2_mq_reg[MQ_W-1:RECIP_SHIFT_3]);
        s3_days_next = day_sum[DAYS_W-1:0];
    end

    logic [DAYS_W-1:0]         s3_days_reg;
    logic [FIELD_W-1:0]        s3_hour_reg;
    logic [FIELD_W-1:0]        s3_min_reg;
    logic [FIELD_W-1:0]        s3_sec_reg;
    logic signed [ZADJ_W-1:0]  s3_zadj_reg;

    // stage 4: hours
    logic [HOURS_W-1:0]        days_ext;
    logic [HOURS_W-1:0]        s4_hours_next;

    always_comb
    begin
        days_ext      = HOURS_W'($signed(s3_days_reg));
        s4_hours_next = (days_ext << 4) + (days_ext << 3) + HOURS_W'(s3_hour_reg);
    end

    logic [HOURS_W-1:0]        s4_hours_reg;
    logic [FIELD_W-1:0]        s4_min_reg;
    logic [FIELD_W-1:0]        s4_sec_reg;
    logic signed [ZADJ_W-1:0]  s4_zadj_reg;

    // stage 5: minutes
    logic [MINS_W-1:0]         hours_ext;
    logic [MINS_W-1:0]         s5_mins_next;

    always_comb
    begin
        hours_ext    = MINS_W'($signed(s4_hours_reg));
        s5_mins_next = (hours_ext << 6) - (hours_ext << 2) + MINS_W'(s4_min_reg);
    end

    logic [MINS_W-1:0]         s5_mins_reg;
    logic [FIELD_W-1:0]        s5_sec_reg;
    logic signed [ZADJ_W-1:0]  s5_zadj_reg;

    // stage 6: seconds, zone removed
    logic [EPOCH_W-1:0]        mins_ext;
    logic [EPOCH_W-1:0]        s6_secs_next;

    always_comb
    begin
        mins_ext     = EPOCH_W'($signed(s5_mins_reg));
        s6_secs_next = (mins_ext << 6) - (mins_ext << 2) + EPOCH_W'(s5_sec_reg)
                     - EPOCH_W'(s5_zadj_reg);
    end

    logic [EPOCH_W-1:0]        s6_secs_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            s1_year_reg  <= s1_year_next;
            s1_pc100_reg <= s1_pc100_next;
            s1_pc400_reg <= s1_pc400_next;
            s1_mprod_reg <= s1_mprod_next;
            s1_day_reg   <= date.day_raw;
            s1_hour_reg  <= date.hour_raw;
            s1_min_reg   <= date.minute_raw;
            s1_sec_reg   <= date.second_raw;
            s1_zadj_reg  <= s1_zadj_next;
        end
        if (ctl.load[1])
        begin
            s2_mq_reg   <= s2_mq_next;
            s2_y365_reg <= s2_y365_next;
            s2_base_reg <= s2_base_next;
            s2_hour_reg <= s1_hour_reg;
            s2_min_reg  <= s1_min_reg;
            s2_sec_reg  <= s1_sec_reg;
            s2_zadj_reg <= s1_zadj_reg;
        end
        if (ctl.load[2])
        begin
            s3_days_reg <= s3_days_next;
            s3_hour_reg <= s2_hour_reg;
            s3_min_reg  <= s2_min_reg;
            s3_sec_reg  <= s2_sec_reg;
            s3_zadj_reg <= s2_zadj_reg;
        end
        if (ctl.load[3])
        begin
            s4_hours_reg <= s4_hours_next;
            s4_min_reg   <= s3_min_reg;
            s4_sec_reg   <= s3_sec_reg;
            s4_zadj_reg  <= s3_zadj_reg;
        end
        if (ctl.load[4])
        begin
            s5_mins_reg <= s5_mins_next;
            s5_sec_reg  <= s4_sec_reg;
            s5_zadj_reg <= s4_zadj_reg;
        end
        if (ctl.load[5])
        begin
            s6_secs_reg <= s6_secs_next;
        end
    end

    assign epoch.valid         = ctl.valid[PIPE_STAGES-1];
    assign epoch.epoch_seconds = $signed(s6_secs_reg);

endmodule

`default_nettype wire

// ===== rtl/idte_pipe_ctrl.sv =====
// Valid/ready control for the converter pipeline: per-stage valid bits and load enables.
// Depends on idte_pkg for the stage count and the control struct.
`default_nettype none

module idte_pipe_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              out_ready,
    output idte_pkg::pipe_ctl_t    ctl
);
    import idte_pkg::*;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || out_ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctl.in_ready = rdy[0];
    assign ctl.load     = rdy;
    assign ctl.valid    = vld_reg;

    logic in_xfer;
    logic out_xfer;
    assign in_xfer  = in_valid && rdy[0];
    assign out_xfer = vld_reg[PIPE_STAGES-1] && out_ready;

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !out_xfer) |=> $countones(vld_reg) == $past($countones(vld_reg)) + 1)
        else $error("item count did not grow on input transfer");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_xfer && out_xfer) |=> $countones(vld_reg) + 1 == $past($countones(vld_reg)))
        else $error("item count did not shrink on output transfer");

    a_room_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != '1) |-> rdy[0])
        else $error("input stalled while a stage is empty");

endmodule

`default_nettype wire

// ===== verif/iso9660_date_to_epoch_tb.sv =====
// Testbench for iso9660_date_to_epoch: a directed date table, checked against typed epochs or a calendar
// predictor, then random dates checked against the predictor across several handshake pressure phases.
// Depends on idte_pkg and the channel interfaces in idte_if.
`default_nettype none

module iso9660_date_to_epoch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idte_pkg::*;

    localparam longint YEAR_ORIGIN    = 1900;
    localparam longint EPOCH_DAY_BIAS = 719499;
    localparam longint ZONE_REACH     = 52;
    localparam longint ZONE_STEP      = 900;
    localparam int     STALL_LIMIT    = 5000;
    localparam int     PHASES         = 8;
    localparam int     PHASE_ITEMS    = 215;
    localparam int     DIR_ROWS       = 25;
    localparam int     PRINT_CAP      = 100;

    localparam int   SRC_IDLE [PHASES] = '{0, 71, 0, 37, 0, 71, 0, 37};
    localparam int   SNK_STALL[PHASES] = '{0, 0, 71, 37, 0, 0, 71, 37};
    localparam logic HS_MODE  [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        logic [FIELD_W-1:0] years_since_1900;
        logic [FIELD_W-1:0] month_raw;
        logic [FIELD_W-1:0] day_raw;
        logic [FIELD_W-1:0] hour_raw;
        logic [FIELD_W-1:0] minute_raw;
        logic [FIELD_W-1:0] second_raw;
        logic [FIELD_W-1:0] zone_byte;
    } date_t;

    typedef struct packed {
        date_t                     date;
        logic                      hs_mode;
        logic                      typed;
        logic signed [EPOCH_W-1:0] epoch;
    } date_row_t;

    logic clk = 1'b0;
    logic rst_n;

    idte_date_if  date_ch();
    idte_epoch_if epoch_ch();
    idte_cfg_if   cfg_ch();

    iso9660_date_to_epoch dut (
        .clk   (clk),
        .rst_n (rst_n),
        .date  (date_ch),
        .epoch (epoch_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic                      hs_mode_now;
    logic                      use_typed;
    logic signed [EPOCH_W-1:0] typed_epoch;
    logic signed [EPOCH_W-1:0] pending_epochs[$];
    int                        src_idle_pct;
    int                        snk_stall_pct;
    int                        mismatches;
    int                        dates_sent;
    int                        epochs_checked;
    int                        quiet_cycles;
    date_row_t                 dir_rows[DIR_ROWS];

    function automatic logic signed [EPOCH_W-1:0] epoch_of(input date_t d, input logic hs);
        longint yr;
        longint mo;
        longint days;
        longint secs;
        longint zone;
        yr = longint'(d.years_since_1900) + YEAR_ORIGIN;
        mo = longint'(d.month_raw) - 2;
        if (mo <= 0)
        begin
            mo = mo + 12;
            yr = yr - 1;
        end
        days = yr / 4 - yr / 100 + yr / 400 + (367 * mo) / 12 + longint'(d.day_raw)
               + yr * 365 - EPOCH_DAY_BIAS;
        secs = ((days * 24 + longint'(d.hour_raw)) * 60 + longint'(d.minute_raw)) * 60
               + longint'(d.second_raw);
        zone = hs ? 64'sd0 : longint'($signed(d.zone_byte));
        if (zone >= -ZONE_REACH && zone <= ZONE_REACH)
            secs = secs - zone * ZONE_STEP;
        return secs[EPOCH_W-1:0];
    endfunction

    function automatic date_row_t mk(input int yr, input int mo, input int dy, input int hr,
                                     input int mi, input int se, input int zn,
                                     input logic hs, input logic typed,
                                     input longint value);
        date_row_t r;
        r.date    = '{yr[7:0], mo[7:0], dy[7:0], hr[7:0], mi[7:0], se[7:0], zn[7:0]};
        r.hs_mode = hs;
        r.typed   = typed;
        r.epoch   = value[EPOCH_W-1:0];
        return r;
    endfunction

    function automatic date_t random_date();
        date_t d;
        if ($urandom_range(99) < 75)
        begin
            d.years_since_1900 = 8'($urandom_range(255));
            d.month_raw        = 8'($urandom_range(12, 1));
            d.day_raw          = 8'($urandom_range(31, 1));
            d.hour_raw         = 8'($urandom_range(23));
            d.minute_raw       = 8'($urandom_range(59));
            d.second_raw       = 8'($urandom_range(59));
            case ($urandom_range(5))
                0: d.zone_byte = 8'($urandom);
                1:
                begin
                    case ($urandom_range(5))
                        0: d.zone_byte = 8'd52;
                        1: d.zone_byte = 8'hCC;
                        2: d.zone_byte = 8'd53;
                        3: d.zone_byte = 8'hCB;
                        4: d.zone_byte = 8'h80;
                        default: d.zone_byte = 8'h7F;
                    endcase
                end
                default: d.zone_byte = 8'($urandom_range(104) - 52);
            endcase
        end
        else
            d = date_t'(56'({$urandom, $urandom}));
        return d;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_date(input date_t d, input logic typed, input logic signed [EPOCH_W-1:0] v);
        @(negedge clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            date_ch.valid <= 1'b0;
            @(negedge clk);
        end
        date_ch.valid            <= 1'b1;
        date_ch.years_since_1900 <= d.years_since_1900;
        date_ch.month_raw        <= d.month_raw;
        date_ch.day_raw          <= d.day_raw;
        date_ch.hour_raw         <= d.hour_raw;
        date_ch.minute_raw       <= d.minute_raw;
        date_ch.second_raw       <= d.second_raw;
        date_ch.zone_byte        <= d.zone_byte;
        use_typed                <= typed;
        typed_epoch              <= v;
        do
            @(posedge clk);
        while (!date_ch.ready);
    endtask

    task automatic write_mode(input logic m);
        @(negedge clk);
        date_ch.valid <= 1'b0;
        while (pending_epochs.size() != 0)
            @(negedge clk);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.high_sierra_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // track mode, queue expected epochs, check results, count quiet cycles
    always @(posedge clk)
    begin
        logic signed [EPOCH_W-1:0] want;
        logic                      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                hs_mode_now = cfg_ch.high_sierra_mode;
                moved = 1'b1;
            end
            if (date_ch.valid && date_ch.ready)
            begin
                want = use_typed ? typed_epoch :
                       epoch_of(date_t'({date_ch.years_since_1900, date_ch.month_raw,
                                         date_ch.day_raw, date_ch.hour_raw,
                                         date_ch.minute_raw, date_ch.second_raw,
                                         date_ch.zone_byte}), hs_mode_now);
                pending_epochs.push_back(want);
                dates_sent++;
                moved = 1'b1;
            end
            if (epoch_ch.valid && epoch_ch.ready)
            begin
                moved = 1'b1;
                epochs_checked++;
                if (pending_epochs.size() == 0)
                    flag_mismatch($sformatf("epoch %0d with no date pending",
                                            epoch_ch.epoch_seconds));
                else
                begin
                    want = pending_epochs.pop_front();
                    if (epoch_ch.epoch_seconds !== want)
                        flag_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                                epoch_ch.epoch_seconds, want));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        epoch_ch.ready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);

    initial
    begin
        rst_n                    = 1'b0;
        hs_mode_now              = 1'b0;
        use_typed                = 1'b0;
        typed_epoch              = '0;
        src_idle_pct             = 0;
        snk_stall_pct            = 0;
        mismatches               = 0;
        dates_sent               = 0;
        epochs_checked           = 0;
        quiet_cycles             = 0;
        date_ch.valid            = 1'b0;
        date_ch.years_since_1900 = '0;
        date_ch.month_raw        = '0;
        date_ch.day_raw          = '0;
        date_ch.hour_raw         = '0;
        date_ch.minute_raw       = '0;
        date_ch.second_raw       = '0;
        date_ch.zone_byte        = '0;
        epoch_ch.ready           = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.high_sierra_mode  = 1'b0;

        dir_rows = '{
            mk( 70,   1,   1,   0,   0,   0,    0, 1'b0, 1'b1, 0),
            mk( 70,   1,   1,   0,   0,   1,    0, 1'b0, 1'b1, 1),
            mk( 70,   1,   1,   0,   0,   0,    4, 1'b0, 1'b1, -3600),
            mk( 70,   1,   1,   0,   0,   0,   52, 1'b0, 1'b1, -46800),
            mk( 70,   1,   1,   0,   0,   0, 'hCC, 1'b0, 1'b1, 46800),
            mk( 70,   1,   1,   0,   0,   0,   53, 1'b0, 1'b1, 0),
            mk( 70,   1,   1,   0,   0,   0, 'hCB, 1'b0, 1'b1, 0),
            mk( 70,   1,   1,   0,   0,   0, 'h80, 1'b0, 1'b1, 0),
            mk( 70,   1,   1,   0,   0,   0, 'h7F, 1'b0, 1'b1, 0),
            mk(100,   1,   1,   0,   0,   0,    0, 1'b0, 1'b1, 946684800),
            mk( 70,   1,   0,   0,   0,   0,    0, 1'b0, 1'b1, -86400),
            mk( 70,   1,   1,  24,  60,  60,    0, 1'b0, 1'b1, 90060),
            mk(  0,   0,   0,   0,   0,   0,    0, 1'b0, 1'b0, 0),
            mk(255, 255, 255, 255, 255, 255, 'hFF, 1'b0, 1'b0, 0),
            mk(  0,   1,   1,   0,   0,   0,    0, 1'b0, 1'b0, 0),
            mk(255,  12,  31,  23,  59,  59,    0, 1'b0, 1'b0, 0),
            mk(100,   2,  29,  12,   0,   0,    0, 1'b0, 1'b0, 0),
            mk( 99,   2,  28,   0,   0,   0,    0, 1'b0, 1'b0, 0),
            mk( 70,   0,   1,   0,   0,   0,    0, 1'b0, 1'b0, 0),
            mk( 70,  13,   1,   0,   0,   0,    0, 1'b0, 1'b0, 0),
            mk( 70,   1,   1,   0,   0,   0,    4, 1'b1, 1'b1, 0),
            mk( 70,   1,   1,   0,   0,   0, 'h80, 1'b1, 1'b1, 0),
            mk(255, 255, 255, 255, 255, 255, 'hFF, 1'b1, 1'b0, 0),
            mk(123,   6,  15,   8,  30,   0, 'hDC, 1'b1, 1'b0, 0),
            mk(123,   6,  15,   8,  30,   0, 'hDC, 1'b0, 1'b0, 0)
        };

        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].hs_mode !== hs_mode_now)
                write_mode(dir_rows[i].hs_mode);
            send_date(dir_rows[i].date, dir_rows[i].typed, dir_rows[i].epoch);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_mode(HS_MODE[p]);
            src_idle_pct  = SRC_IDLE[p];
            snk_stall_pct = SNK_STALL[p];
            repeat (PHASE_ITEMS)
                send_date(random_date(), 1'b0, '0);
        end

        // drop valid and drain the pipeline
        @(negedge clk);
        date_ch.valid <= 1'b0;
        while (pending_epochs.size() != 0)
            @(negedge clk);
        repeat (PIPE_STAGES + 4)
            @(negedge clk);
        if (pending_epochs.size() != 0)
            flag_mismatch($sformatf("%0d epochs never arrived", pending_epochs.size()));

        $display("Converted %0d dates (directed table plus random, both zone modes),",
                 dates_sent);
        $display("checked %0d epochs under %0d pressure phases: %0d mismatches",
                 epochs_checked, PHASES, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== iso9660_date_to_epoch.f =====
rtl/idte_pkg.sv
rtl/idte_if.sv
rtl/idte_pipe_ctrl.sv
rtl/iso9660_date_to_epoch.sv
verif/iso9660_date_to_epoch_tb.sv
